// ===== src/pproj_pkg.sv =====
// pproj_pkg: shared types and constants for the pinhole point projection block
// no dependencies
`timescale 1ns / 1ps

package pproj_pkg;

    localparam int COORD_W   = 32;  // q16.16 style coordinate and coefficient width
    localparam int ROWS      = 3;   // rows of the camera matrix
    localparam int COLS      = 4;   // columns of the camera matrix
    localparam int NUM_REGS  = 6;   // matrix registers, two coefficients each
    localparam int REG_W     = 64;  // matrix register width
    localparam int CFG_IDX_W = 3;   // register index width
    localparam int PROD_W    = 64;  // full 32x32 signed product
    localparam int SUM_W     = 66;  // homogeneous row sum, no overflow possible
    localparam int MAG_W     = 64;  // magnitude of a row sum
    localparam int Q_W       = 32;  // quotient bits resolved by the divider

    typedef logic signed [COORD_W-1:0] coef_word_t;
    typedef coef_word_t [ROWS-1:0][COLS-1:0] coef_mat_t;
    typedef logic signed [SUM_W-1:0] row_sum_t;

    // homogeneous point handed from the front end to the divide back end
    typedef struct packed {
        row_sum_t h0;
        row_sum_t h1;
        row_sum_t h2;
    } hpoint_t;

endpackage

// ===== src/pproj_front.sv =====
// pproj_front: accepts world points and forms the homogeneous image point
// depends on pproj_pkg
`timescale 1ns / 1ps

module pproj_front #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  pproj_pkg::coef_mat_t                  coef,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [pproj_pkg::COORD_W-1:0]  world_x,
    input  logic signed [pproj_pkg::COORD_W-1:0]  world_y,
    input  logic signed [pproj_pkg::COORD_W-1:0]  world_z,
    input  logic                                  q_full,
    output logic                                  q_push,
    output pproj_pkg::hpoint_t                    q_item
);

    logic signed [pproj_pkg::PROD_W-1:0] prod_reg [pproj_pkg::ROWS][3];
    logic signed [pproj_pkg::SUM_W-1:0]  col3_reg [pproj_pkg::ROWS];
    logic                                v1_reg;
    logic                                v2_reg;
    pproj_pkg::hpoint_t                  item_reg;
    pproj_pkg::row_sum_t                 sum_next [pproj_pkg::ROWS];
    logic                                adv;

    assign adv      = !v2_reg || !q_full;
    assign in_ready = adv;
    assign q_push   = v2_reg && !q_full;
    assign q_item   = item_reg;

    // stage 1: the nine multiplies plus the scaled translation column
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int r = 0; r < pproj_pkg::ROWS; r++)
            begin
                prod_reg[r][0] <= $signed(coef[r][0]) * world_x;
                prod_reg[r][1] <= $signed(coef[r][1]) * world_y;
                prod_reg[r][2] <= $signed(coef[r][2]) * world_z;
                col3_reg[r]    <= pproj_pkg::SUM_W'($signed(coef[r][3])) <<< FRACTION_BITS;
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < pproj_pkg::ROWS; r++)
        begin
            sum_next[r] = pproj_pkg::SUM_W'(prod_reg[r][0])
                        + pproj_pkg::SUM_W'(prod_reg[r][1])
                        + pproj_pkg::SUM_W'(prod_reg[r][2])
                        + col3_reg[r];
        end
    end

    // stage 2: row sums
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg.h0 <= sum_next[0];
            item_reg.h1 <= sum_next[1];
            item_reg.h2 <= sum_next[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

endmodule

// ===== src/pproj_fifo.sv =====
// pproj_fifo: two-entry queue between the front end and the divide back end
// depends on pproj_pkg
`timescale 1ns / 1ps

module pproj_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pproj_pkg::hpoint_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               valid,
    output pproj_pkg::hpoint_t head
);

    pproj_pkg::hpoint_t mem_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/pproj_div.sv =====
// pproj_div: pipelined restoring divider, one quotient bit per stage
// depends on pproj_pkg
`timescale 1ns / 1ps

module pproj_div #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                            clk,
    input  logic                            en,
    input  logic [pproj_pkg::MAG_W-1:0]     num,
    input  logic [pproj_pkg::MAG_W-1:0]     den,
    output logic [pproj_pkg::Q_W-1:0]       quo,
    output logic                            ovf
);

    localparam int NW = pproj_pkg::MAG_W + FRACTION_BITS;
    localparam int QW = pproj_pkg::Q_W;
    localparam int MW = pproj_pkg::MAG_W;

    logic [NW-1:0] nshift;
    logic [MW-1:0] rinit;

    logic [MW-1:0] rem_reg [QW+1];
    logic [QW-1:0] low_reg [QW+1];
    logic [QW-1:0] quo_reg [QW+1];
    logic [MW-1:0] den_reg [QW+1];
    logic          ovf_reg [QW+1];

    // numerator scaled by the fraction, split into the part above the quotient
    // window and the bits still to be shifted in
    assign nshift = {num, {FRACTION_BITS{1'b0}}};
    assign rinit  = MW'(nshift[NW-1:QW]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rinit;
            low_reg[0] <= nshift[QW-1:0];
            quo_reg[0] <= '0;
            den_reg[0] <= den;
            ovf_reg[0] <= (rinit >= den);
        end
    end

    for (genvar s = 0; s < QW; s++)
    begin : g_stage
        logic [MW:0] trial;
        logic        take;

        assign trial = {rem_reg[s], low_reg[s][QW-1]};
        assign take  = (trial >= {1'b0, den_reg[s]});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s+1] <= take ? MW'(trial - {1'b0, den_reg[s]}) : trial[MW-1:0];
                low_reg[s+1] <= {low_reg[s][QW-2:0], 1'b0};
                quo_reg[s+1] <= {quo_reg[s][QW-2:0], take};
                den_reg[s+1] <= den_reg[s];
                ovf_reg[s+1] <= ovf_reg[s];
            end
        end
    end

    assign quo = quo_reg[QW];
    assign ovf = ovf_reg[QW];

endmodule

// ===== src/pproj_back.sv =====
// pproj_back: sign handling, the two divides and saturation into the output register
// depends on pproj_pkg and pproj_div
`timescale 1ns / 1ps

module pproj_back #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  q_valid,
    input  pproj_pkg::hpoint_t                    q_head,
    output logic                                  q_pop,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [pproj_pkg::COORD_W-1:0]  image_u,
    output logic signed [pproj_pkg::COORD_W-1:0]  image_v,
    output logic                                  divide_by_zero,
    output logic                                  saturated
);

    localparam int DEPTH = pproj_pkg::Q_W + 2;
    localparam int MW    = pproj_pkg::MAG_W;
    localparam int QW    = pproj_pkg::Q_W;

    typedef struct packed {
        logic neg_u;
        logic neg_v;
        logic dz;
    } side_t;

    logic          adv;
    logic [MW-1:0] mag0_reg;
    logic [MW-1:0] mag1_reg;
    logic [MW-1:0] mag2_reg;
    side_t         side_reg  [DEPTH];
    logic          valid_reg [DEPTH];
    logic [QW-1:0] qu;
    logic [QW-1:0] qv;
    logic          ovf_u;
    logic          ovf_v;
    logic          out_valid_reg;
    logic [QW-1:0] u_reg;
    logic [QW-1:0] v_reg;
    logic          dz_reg;
    logic          sat_reg;
    logic [QW-1:0] u_next;
    logic [QW-1:0] v_next;
    logic          sat_u;
    logic          sat_v;
    side_t         last;

    assign adv   = !out_valid_reg || out_ready;
    assign q_pop = q_valid && adv;

    function automatic logic [MW-1:0] magnitude(input pproj_pkg::row_sum_t h);
        pproj_pkg::row_sum_t a;
        a = h[pproj_pkg::SUM_W-1] ? -h : h;
        return a[MW-1:0];
    endfunction

    // quotient to signed result, clamped to the 32-bit range
    function automatic logic [QW:0] finish(input logic [QW-1:0] q, input logic ov,
                                           input logic neg);
        logic [QW-1:0] val;
        logic          sat;
        if (!neg)
        begin
            sat = ov || q[QW-1];
            val = sat ? {1'b0, {(QW-1){1'b1}}} : q;
        end
        else
        begin
            sat = ov || (q[QW-1] && (q[QW-2:0] != '0));
            val = sat ? {1'b1, {(QW-1){1'b0}}} : -q;
        end
        return {sat, val};
    endfunction

    // stage a: magnitudes, quotient signs and the zero divisor check
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag0_reg        <= magnitude(q_head.h0);
            mag1_reg        <= magnitude(q_head.h1);
            mag2_reg        <= magnitude(q_head.h2);
            side_reg[0].dz  <= (q_head.h2 == '0);
            side_reg[0].neg_u <= (q_head.h0[pproj_pkg::SUM_W-1] != q_head.h2[pproj_pkg::SUM_W-1])
                                 && (q_head.h0 != '0);
            side_reg[0].neg_v <= (q_head.h1[pproj_pkg::SUM_W-1] != q_head.h2[pproj_pkg::SUM_W-1])
                                 && (q_head.h1 != '0);
            for (int i = 1; i < DEPTH; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            valid_reg[0] <= q_valid;
            for (int i = 1; i < DEPTH; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    pproj_div #(.FRACTION_BITS(FRACTION_BITS)) u_div_u (
        .clk (clk),
        .en  (adv),
        .num (mag0_reg),
        .den (mag2_reg),
        .quo (qu),
        .ovf (ovf_u)
    );

    pproj_div #(.FRACTION_BITS(FRACTION_BITS)) u_div_v (
        .clk (clk),
        .en  (adv),
        .num (mag1_reg),
        .den (mag2_reg),
        .quo (qv),
        .ovf (ovf_v)
    );

    assign last = side_reg[DEPTH-1];
    assign {sat_u, u_next} = finish(qu, ovf_u, last.neg_u);
    assign {sat_v, v_next} = finish(qv, ovf_v, last.neg_v);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u_reg   <= last.dz ? '0 : u_next;
            v_reg   <= last.dz ? '0 : v_next;
            dz_reg  <= last.dz;
            sat_reg <= !last.dz && (sat_u || sat_v);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= valid_reg[DEPTH-1];
        end
    end

    assign out_valid      = out_valid_reg;
    assign image_u        = $signed(u_reg);
    assign image_v        = $signed(v_reg);
    assign divide_by_zero = dz_reg;
    assign saturated      = sat_reg;

endmodule

// ===== src/pinhole_point_projection.sv =====
// pinhole_point_projection: projects world points through a 3x4 camera matrix
// throughput: one point per cycle while out_ready is held high, set by the one-bit-per-stage divider pipelines
// reset: matrix registers clear to zero, every pipeline and queue empties
// depends on pproj_pkg, pproj_front, pproj_fifo, pproj_back
`timescale 1ns / 1ps

module pinhole_point_projection #(
    parameter int FRACTION_BITS = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // matrix register write port
    input  logic                                  wr_en,
    input  logic [pproj_pkg::CFG_IDX_W-1:0]       wr_index,
    input  logic [pproj_pkg::REG_W-1:0]           wr_data,
    // world point channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [pproj_pkg::COORD_W-1:0]  world_x,
    input  logic signed [pproj_pkg::COORD_W-1:0]  world_y,
    input  logic signed [pproj_pkg::COORD_W-1:0]  world_z,
    // image point channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [pproj_pkg::COORD_W-1:0]  image_u,
    output logic signed [pproj_pkg::COORD_W-1:0]  image_v,
    output logic                                  divide_by_zero,
    output logic                                  saturated
);

    // matrix storage: each register packs two coefficients, low half first
    logic [pproj_pkg::REG_W-1:0] matrix_reg [pproj_pkg::NUM_REGS];
    pproj_pkg::coef_mat_t        coef;

    // front end to queue
    logic               q_push;
    logic               q_full;
    pproj_pkg::hpoint_t q_item;

    // queue to back end
    logic               q_valid;
    logic               q_pop;
    pproj_pkg::hpoint_t q_head;

    // writes beyond the last register are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < pproj_pkg::NUM_REGS; i++)
            begin
                matrix_reg[i] <= '0;
            end
        end
        else if (wr_en && (wr_index < pproj_pkg::CFG_IDX_W'(pproj_pkg::NUM_REGS)))
        begin
            matrix_reg[wr_index] <= wr_data;
        end
    end

    // unpack the coefficients in row-major order
    for (genvar r = 0; r < pproj_pkg::ROWS; r++)
    begin : g_row
        for (genvar c = 0; c < pproj_pkg::COLS; c++)
        begin : g_col
            localparam int K = r * pproj_pkg::COLS + c;
            if (K % 2 == 0)
            begin : g_lo
                assign coef[r][c] = $signed(matrix_reg[K/2][pproj_pkg::COORD_W-1:0]);
            end
            else
            begin : g_hi
                assign coef[r][c] =
                    $signed(matrix_reg[K/2][pproj_pkg::REG_W-1:pproj_pkg::COORD_W]);
            end
        end
    end

    // front end: multiplies and row sums, two stages
    pproj_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .coef     (coef),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .world_x  (world_x),
        .world_y  (world_y),
        .world_z  (world_z),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (q_item)
    );

    // short queue so that each side stalls on its own
    pproj_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_item),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .head      (q_head)
    );

    // back end: sign handling, both divides in parallel, clamp and output register
    pproj_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .image_u        (image_u),
        .image_v        (image_v),
        .divide_by_zero (divide_by_zero),
        .saturated      (saturated)
    );

endmodule

// ===== tb/sv/tb.sv =====
// tb: self-checking bench for pinhole_point_projection, with a scoreboard class
// predicts each image point from the camera matrix in the bench; depends on pproj_pkg
`timescale 1ns / 1ps

module tb;

    localparam int FB = 16;
    localparam int LATENCY = 37;
    localparam int LIMIT = 400000;

    typedef struct packed {
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic dz;
        logic sat;
    } image_pt_t;

    // scoreboard: holds the matrix copy and the queue of predicted image points
    class projection_sb;
        logic [63:0] mat [pproj_pkg::NUM_REGS];
        image_pt_t pending [$];
        int errors = 0;

        function new();
            foreach (mat[i]) mat[i] = '0;
        endfunction

        function logic signed [31:0] coef_at(int r, int c);
            int k;
            k = r * 4 + c;
            return (k % 2) ? mat[k / 2][63:32] : mat[k / 2][31:0];
        endfunction

        function logic signed [65:0] row_sum(int r, logic signed [31:0] x,
                                             logic signed [31:0] y,
                                             logic signed [31:0] z);
            logic signed [65:0] s;
            s = 66'(coef_at(r, 0)) * 66'(x) + 66'(coef_at(r, 1)) * 66'(y)
                + 66'(coef_at(r, 2)) * 66'(z) + (66'(coef_at(r, 3)) <<< FB);
            return s;
        endfunction

        // divide with truncation toward zero, then clamp to 32 bits
        function logic [31:0] divide_clamp(logic signed [65:0] n,
                                           logic signed [65:0] d, ref logic sat);
            logic [127:0] nm, dm, q;
            logic neg;
            nm = n[65] ? 128'(-n) : 128'(n);
            dm = d[65] ? 128'(-d) : 128'(d);
            neg = (n[65] != d[65]) && n != 0;
            q = (nm << FB) / dm;
            if (!neg)
            begin
                if (q > 128'h7FFF_FFFF)
                begin
                    sat = 1'b1;
                    return 32'h7FFF_FFFF;
                end
                return q[31:0];
            end
            if (q > 128'h8000_0000)
            begin
                sat = 1'b1;
                return 32'h8000_0000;
            end
            return 32'(-q[31:0]);
        endfunction

        function void note_point(logic signed [31:0] x, logic signed [31:0] y,
                                 logic signed [31:0] z);
            logic signed [65:0] h0, h1, h2;
            image_pt_t e;
            logic s;
            h0 = row_sum(0, x, y, z);
            h1 = row_sum(1, x, y, z);
            h2 = row_sum(2, x, y, z);
            s = 1'b0;
            e = '0;
            if (h2 == 0)
            begin
                e.dz = 1'b1;
            end
            else
            begin
                e.u = divide_clamp(h0, h2, s);
                e.v = divide_clamp(h1, h2, s);
                e.sat = s;
            end
            pending.push_back(e);
        endfunction

        function void check_point(image_pt_t got);
            image_pt_t e;
            if (pending.size() == 0)
            begin
                $error("image point with nothing expected");
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.u !== e.u)
            begin
                $error("image_u expected %h got %h", e.u, got.u);
                errors++;
            end
            if (got.v !== e.v)
            begin
                $error("image_v expected %h got %h", e.v, got.v);
                errors++;
            end
            if (got.dz !== e.dz)
            begin
                $error("divide_by_zero expected %b got %b", e.dz, got.dz);
                errors++;
            end
            if (got.sat !== e.sat)
            begin
                $error("saturated expected %b got %b", e.sat, got.sat);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic wr_en = 1'b0;
    logic [pproj_pkg::CFG_IDX_W-1:0] wr_index = '0;
    logic [pproj_pkg::REG_W-1:0] wr_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] world_x = '0, world_y = '0, world_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] image_u, image_v;
    logic divide_by_zero, saturated;

    projection_sb sb = new();
    int cycle_count = 0;
    bit quiet_tail = 0;    // no idling near the end
    bit hold_off = 0;      // long receiver stall request
    int points_sent = 0;

    always #5 clk = ~clk;

    pinhole_point_projection #(.FRACTION_BITS(FB)) DUT (
        .clk(clk), .rst_n(rst_n),
        .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .world_x(world_x), .world_y(world_y), .world_z(world_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .image_u(image_u), .image_v(image_v),
        .divide_by_zero(divide_by_zero), .saturated(saturated)
    );

    // timeout guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    // result side: sample each output transaction, then pick the next ready
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                sb.check_point({image_u, image_v, divide_by_zero, saturated});
            if (hold_off)
            begin
                out_ready <= 1'b0;
                // long stall counted here so the pipeline fills and in_ready drops
                repeat (200) @(posedge clk);
                hold_off = 0;
                out_ready <= 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 9);
                out_ready <= 1'b0;
                // ready is low, so no transaction can complete on these edges
                repeat (gap - 1) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    // single register write, block is idle
    task automatic write_reg(int idx, logic [63:0] val);
        @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= pproj_pkg::CFG_IDX_W'(idx);
        wr_data <= val;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx < pproj_pkg::NUM_REGS)
            sb.mat[idx] = val;
    endtask

    task automatic load_matrix(logic [63:0] m [pproj_pkg::NUM_REGS]);
        for (int i = 0; i < pproj_pkg::NUM_REGS; i++)
            write_reg(i, m[i]);
    endtask

    // offer one world point and hold it until the transaction completes
    task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z);
        int gap;
        if (!quiet_tail && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 9);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        world_x <= x;
        world_y <= y;
        world_z <= z;
        do @(posedge clk); while (!in_ready);
        sb.note_point(x, y, z);
        points_sent++;
    endtask

    task automatic drain();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 40 << FB)) - (20 << FB));
            default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    // packs two coefficients into one matrix register, the first one in the low half
    function automatic logic [63:0] pack2(logic [31:0] a, logic [31:0] b);
        return {b, a};
    endfunction

    initial
    begin
        logic [63:0] m [pproj_pkg::NUM_REGS];
        logic [31:0] c [12];
        int phase;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero matrix after reset: every point divides by zero
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        send_point('0, '0, '0);
        in_valid <= 1'b0;
        drain();

        // identity-like camera, unit divisor from z
        m[0] = pack2(32'h0001_0000, 0); m[1] = pack2(0, 0);
        m[2] = pack2(0, 32'h0001_0000); m[3] = pack2(0, 0);
        m[4] = pack2(0, 0);             m[5] = pack2(32'h0001_0000, 0);
        load_matrix(m);
        write_reg(7, 64'hFFFF_FFFF_FFFF_FFFF);    // out of range, ignored
        send_point(32'h0002_0000, 32'hFFFF_0000, 32'h0001_0000);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);    // both clamps
        send_point(32'h8000_0000, 32'h0000_0000, 32'h0001_0000);    // exactly -2^31
        send_point(32'h0001_0000, 32'h0001_0000, 32'h0000_0000);    // zero divisor
        send_point(32'h0003_0000, 32'hFFFD_0000, 32'hFFFF_0000);    // negative divisor
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF);
        in_valid <= 1'b0;
        drain();

        // extreme coefficients
        m[0] = 64'h8000_0000_7FFF_FFFF; m[1] = 64'h7FFF_FFFF_8000_0000;
        m[2] = 64'hFFFF_FFFF_FFFF_FFFF; m[3] = 64'h8000_0000_8000_0000;
        m[4] = 64'h7FFF_FFFF_7FFF_FFFF; m[5] = 64'h8000_0000_0000_0001;
        load_matrix(m);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        send_point('0, '0, '0);
        in_valid <= 1'b0;
        drain();

        // random phases with differing matrices
        for (phase = 0; phase < 6; phase++)
        begin
            for (int i = 0; i < 12; i++)
            begin
                if (phase % 3 == 0)
                    c[i] = $urandom();
                else
                    c[i] = 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
            end
            if (phase % 3 != 0)
            begin
                c[8] = 0; c[9] = 0;
                c[10] = 32'h0001_0000;
                c[11] = ($urandom_range(0, 3) == 0) ? 0 : 32'($urandom_range(0, 1 << 18));
            end
            for (int i = 0; i < pproj_pkg::NUM_REGS; i++)
                m[i] = pack2(c[2 * i], c[2 * i + 1]);
            load_matrix(m);
            if (phase == 4)
                hold_off = 1;
            if (phase == 5)
                quiet_tail = 1;
            for (int n = 0; n < 72; n++)
                send_point(rand_coord($urandom_range(0, 2)),
                           rand_coord($urandom_range(0, 2)),
                           ($urandom_range(0, 15) == 0) ? 32'h0 :
                           rand_coord($urandom_range(0, 2)));
            in_valid <= 1'b0;
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== sim.f =====
src/pproj_pkg.sv
src/pproj_front.sv
src/pproj_fifo.sv
src/pproj_div.sv
src/pproj_back.sv
src/pinhole_point_projection.sv
tb/sv/tb.sv
